// ----- hw/rtl/qpb_pkg.sv -----
// Shared types and constants of the quadtree pyramid builder.
// Used by the top level and its checker; depends on nothing.
`default_nettype none

package qpb_pkg;

	localparam int LEVEL_W  = 4;
	localparam int MEAN_W   = 8;
	localparam int SPREAD_W = 16;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EMIT,
		ST_SUMS,
		ST_MUL,
		ST_RGO,
		ST_SQRT
	} state_t;

	// One held child node
	typedef struct packed {
		logic [MEAN_W-1:0]   mean;
		logic                uni;
		logic [SPREAD_W-1:0] spread;
	} node_t;

endpackage

`default_nettype wire

// ----- hw/rtl/qpb_isqrt.sv -----
// Iterative integer square root, two radicand bits per cycle, truncated.
// Standalone unit driven by the pyramid builder sequencer; no package use.
`default_nettype none

module qpb_isqrt #(
	parameter int ACC_W = 35
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [ACC_W-1:0] radicand,
	output logic                  done,
	output logic      [ACC_W-1:0] root
);

	localparam int BIT_TOP = ((ACC_W - 1) / 2) * 2;
	localparam int STEPS   = BIT_TOP / 2 + 1;
	localparam int STEP_W  = (STEPS > 1) ? $clog2(STEPS) : 1;

	logic [ACC_W-1:0]  x_q, res_q, bit_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q, done_q;
	logic [ACC_W-1:0]  trial;

	assign trial = ACC_W'(res_q + bit_q);

	// Advance one digit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= STEP_W'(STEPS - 1);
		end else if (busy_q) begin
			if (step_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				step_q <= step_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= radicand;
			res_q <= '0;
			bit_q <= ACC_W'(1) << BIT_TOP;
		end else if (busy_q) begin
			if (x_q >= trial) begin
				x_q   <= x_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = res_q;

endmodule

`default_nettype wire

// ----- hw/rtl/quadtree_pyramid_builder.sv -----
// Quadtree pyramid builder: leaf result in the cycle after a pixel request is taken.
// After its child result is taken, each parent is built by multiply-accumulates on
// one shared squarer plus the iterative square root of STEPS digits (18 at defaults).
// A new pixel is taken once the last result of the previous one is taken. Reset
// clears counts and sequencer; tree_levels resets to 9. Child slots need no clearing.
`default_nettype none

module quadtree_pyramid_builder #(
	parameter int MAX_LEVELS       = 10,
	parameter int SPREAD_FRAC_BITS = 8
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [qpb_pkg::LEVEL_W-1:0]  cfg_wdata,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [qpb_pkg::MEAN_W-1:0]   pixel,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [qpb_pkg::MEAN_W-1:0]        node_mean,
	output logic [1:0]                        node_remainder,
	output logic                              node_uniform,
	output logic [qpb_pkg::SPREAD_W-1:0]      node_spread,
	output logic [qpb_pkg::LEVEL_W-1:0]       node_level,
	output logic                              is_root,
	output logic                              last
);

	localparam int IDX_W  = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
	localparam int DSH    = 2 * SPREAD_FRAC_BITS;
	localparam int ACC_W  = ((34 > 18 + DSH) ? 34 : 18 + DSH) + 1;
	localparam logic [qpb_pkg::LEVEL_W-1:0] MAX_LEV = qpb_pkg::LEVEL_W'(MAX_LEVELS);

	qpb_pkg::state_t state_q, state_nx;

	logic [qpb_pkg::LEVEL_W-1:0] tree_levels_q, root_q, lev_q, root_sat, nlev;
	logic [1:0]                  cnt_q [MAX_LEVELS];
	qpb_pkg::node_t              slot_mem [3][MAX_LEVELS];
	qpb_pkg::node_t              rd_q [3];

	logic [qpb_pkg::MEAN_W-1:0]   cur_mean_q, mean_q;
	logic                         cur_uni_q, uni_q;
	logic [qpb_pkg::SPREAD_W-1:0] cur_spread_q;
	logic [1:0]                   rem_q;
	logic [ACC_W-1:0]             acc_q;
	logic [2:0]                   k_q;
	logic                         last_q;

	logic                         in_take, out_take, sqrt_start, sqrt_done;
	logic [ACC_W-1:0]             sqrt_root;
	logic [IDX_W-1:0]             lev_idx, nlev_idx;

	assign root_sat = (tree_levels_q > MAX_LEV) ? MAX_LEV : tree_levels_q;
	assign nlev     = lev_q + 1'b1;
	assign lev_idx  = lev_q[IDX_W-1:0];
	assign nlev_idx = nlev[IDX_W-1:0];
	assign in_take  = in_valid && in_ready;
	assign out_take = out_valid && out_ready;

	// Child view for parent arithmetic
	logic [qpb_pkg::MEAN_W-1:0]   ch_mean [4];
	logic                         ch_uni  [4];
	logic [qpb_pkg::SPREAD_W-1:0] ch_spr  [4];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ch_mean[i] = rd_q[i].mean;
			ch_uni[i]  = rd_q[i].uni;
			ch_spr[i]  = rd_q[i].spread;
		end
		ch_mean[3] = cur_mean_q;
		ch_uni[3]  = cur_uni_q;
		ch_spr[3]  = cur_spread_q;
	end

	// Parent sum, mean, remainder, uniform flag
	logic [9:0] sum4;
	logic       uni4;
	assign sum4 = 10'(ch_mean[0]) + 10'(ch_mean[1]) + 10'(ch_mean[2]) + 10'(ch_mean[3]);
	assign uni4 = (sum4[1:0] == 2'd0) && ch_uni[0] && ch_uni[1] && ch_uni[2] && ch_uni[3]
		&& (ch_mean[0] == ch_mean[1]) && (ch_mean[1] == ch_mean[2])
		&& (ch_mean[2] == ch_mean[3]);

	// Shared squarer: spreads first, then mean deviations
	logic [qpb_pkg::MEAN_W-1:0]   dm, dsel;
	logic [qpb_pkg::SPREAD_W-1:0] sq_op;
	logic [31:0]                  prod;
	logic [ACC_W-1:0]             term;
	always_comb begin
		dsel  = ch_mean[k_q[1:0]];
		dm    = (mean_q >= dsel) ? (mean_q - dsel) : (dsel - mean_q);
		sq_op = k_q[2] ? 16'(dm) : ch_spr[k_q[1:0]];
		prod  = 32'(sq_op) * 32'(sq_op);
		term  = k_q[2] ? (ACC_W'(prod) << DSH) : ACC_W'(prod);
	end

	qpb_isqrt #(.ACC_W(ACC_W)) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (acc_q),
		.done     (sqrt_done),
		.root     (sqrt_root)
	);

	// Truncate and saturate the spread
	logic [ACC_W-2:0]             sq_half;
	logic [qpb_pkg::SPREAD_W-1:0] spread_sat;
	assign sq_half    = sqrt_root[ACC_W-1:1];
	assign spread_sat = (|sq_half[ACC_W-2:qpb_pkg::SPREAD_W]) ? '1
		: sq_half[qpb_pkg::SPREAD_W-1:0];

	logic fin, par_root, par_last, leaf_last;
	assign fin       = (state_q == qpb_pkg::ST_SQRT) && sqrt_done;
	assign par_root  = (nlev == root_q);
	assign par_last  = par_root || (cnt_q[nlev_idx] != 2'd3);
	assign leaf_last = (root_sat == '0) || (cnt_q[0] != 2'd3);

	// Slot write request
	logic                         wr_en;
	logic [IDX_W-1:0]             wr_idx;
	logic [1:0]                   wr_slot;
	qpb_pkg::node_t               wr_node;
	always_comb begin
		wr_en   = 1'b0;
		wr_idx  = '0;
		wr_slot = cnt_q[0];
		wr_node = '{mean: pixel, uni: 1'b1, spread: '0};
		if (in_take && leaf_last && (root_sat != '0)) begin
			wr_en = 1'b1;
		end else if (fin && !par_root && par_last) begin
			wr_en   = 1'b1;
			wr_idx  = nlev_idx;
			wr_slot = cnt_q[nlev_idx];
			wr_node = '{mean: sum4[9:2] , uni: uni_q, spread: spread_sat};
		end
	end

	// Child slot memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_mem[wr_slot][wr_idx] <= wr_node;
		end
		for (int i = 0; i < 3; i++) begin
			rd_q[i] <= slot_mem[i][lev_idx];
		end
	end

	// Next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			qpb_pkg::ST_IDLE: if (in_take) state_nx = qpb_pkg::ST_EMIT;
			qpb_pkg::ST_EMIT: begin
				if (out_take) state_nx = last_q ? qpb_pkg::ST_IDLE : qpb_pkg::ST_SUMS;
			end
			qpb_pkg::ST_SUMS: state_nx = qpb_pkg::ST_MUL;
			qpb_pkg::ST_MUL:  if (k_q == 3'd7) state_nx = qpb_pkg::ST_RGO;
			qpb_pkg::ST_RGO:  state_nx = qpb_pkg::ST_SQRT;
			qpb_pkg::ST_SQRT: if (sqrt_done) state_nx = qpb_pkg::ST_EMIT;
			default:          state_nx = qpb_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		in_ready   = (state_q == qpb_pkg::ST_IDLE);
		out_valid  = (state_q == qpb_pkg::ST_EMIT);
		sqrt_start = (state_q == qpb_pkg::ST_RGO);
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= qpb_pkg::ST_IDLE;
			tree_levels_q <= qpb_pkg::LEVEL_W'(9);
			lev_q         <= '0;
			root_q        <= '0;
			k_q           <= '0;
			for (int i = 0; i < MAX_LEVELS; i++) cnt_q[i] <= 2'd0;
		end else begin
			state_q <= state_nx;
			if (cfg_we) tree_levels_q <= cfg_wdata;
			if (state_q == qpb_pkg::ST_SUMS) k_q <= '0;
			else if (state_q == qpb_pkg::ST_MUL) k_q <= k_q + 1'b1;
			if (in_take) begin
				lev_q  <= '0;
				root_q <= root_sat;
				if (root_sat == '0) begin
					for (int i = 0; i < MAX_LEVELS; i++) cnt_q[i] <= 2'd0;
				end else if (leaf_last) begin
					cnt_q[0] <= cnt_q[0] + 1'b1;
				end
			end else if (fin) begin
				lev_q <= nlev;
				if (par_root) begin
					for (int i = 0; i < MAX_LEVELS; i++) cnt_q[i] <= 2'd0;
				end else begin
					cnt_q[lev_idx] <= 2'd0;
					if (par_last) begin
						cnt_q[nlev_idx] <= cnt_q[nlev_idx] + 1'b1;
					end
				end
			end
		end
	end

	// Datapath and result registers
	always_ff @(posedge clk) begin
		if (in_take) begin
			cur_mean_q     <= pixel;
			cur_uni_q      <= 1'b1;
			cur_spread_q   <= '0;
			node_mean      <= pixel;
			node_remainder <= 2'd0;
			node_uniform   <= 1'b1;
			node_spread    <= '0;
			node_level     <= '0;
			is_root        <= (root_sat == '0);
			last_q         <= leaf_last;
		end
		if (state_q == qpb_pkg::ST_SUMS) begin
			mean_q <= sum4[9:2];
			rem_q  <= sum4[1:0];
			uni_q  <= uni4;
			acc_q  <= '0;
		end
		if (state_q == qpb_pkg::ST_MUL) begin
			acc_q <= acc_q + term;
		end
		if (fin) begin
			cur_mean_q     <= mean_q;
			cur_uni_q      <= uni_q;
			cur_spread_q   <= spread_sat;
			node_mean      <= mean_q;
			node_remainder <= rem_q;
			node_uniform   <= uni_q;
			node_spread    <= spread_sat;
			node_level     <= nlev;
			is_root        <= par_root;
			last_q         <= par_last;
		end
	end

	assign last = last_q;

endmodule

`default_nettype wire

// ----- hw/rtl/qpb_checker.sv -----
// Port-level checks for the quadtree pyramid builder, bound to the top level.
// Depends on qpb_pkg for field widths.
`default_nettype none

module qpb_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         in_valid,
	input wire logic                         in_ready,
	input wire logic                         out_valid,
	input wire logic                         out_ready,
	input wire logic [qpb_pkg::MEAN_W-1:0]   node_mean,
	input wire logic [qpb_pkg::SPREAD_W-1:0] node_spread,
	input wire logic [qpb_pkg::LEVEL_W-1:0]  node_level,
	input wire logic                         is_root,
	input wire logic                         last
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(node_mean)
			&& $stable(node_spread) && $stable(node_level) && $stable(last))
		else $error("stalled result changed");

	// Never take a pixel while a result waits
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input ready while result pending");

	// Emit the leaf right after a pixel request is taken
	a_leaf: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid && node_level == '0)
		else $error("leaf not emitted");

	// A root always ends the chain
	a_root_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_root |-> last)
		else $error("root without last");

endmodule

bind quadtree_pyramid_builder qpb_checker u_qpb_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.node_mean   (node_mean),
	.node_spread (node_spread),
	.node_level  (node_level),
	.is_root     (is_root),
	.last        (last)
);

`default_nettype wire
